>>> rtl/pqs_pkg.sv
// Shared types and constants for the positional queue store.
`default_nettype none

package pqs_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned CNT_W   = 5;
    // wide enough to name any slot of the largest supported store
    localparam int unsigned SLOT_W  = 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_POP    = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // broadcast to every cell; each cell decides its own move from slot
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/pqs_cell.sv
// One storage cell of the queue: holds one entry and shifts with its neighbors.
`default_nettype none

module pqs_cell
    import pqs_pkg::*;
#(
    parameter int unsigned INDEX = 0
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [DATA_W-1:0] i_prev,
    input  wire logic [DATA_W-1:0] i_next,
    output logic      [DATA_W-1:0] o_entry
);

    localparam logic [SLOT_W-1:0] IDX = SLOT_W'(INDEX);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.ins) begin
            // open the gap: cells behind the slot take their left neighbor
            if (IDX > i_ctl.slot) begin
                n_entry = i_prev;
            end else if (IDX == i_ctl.slot) begin
                n_entry = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            // close the gap: cells from the slot on take their right neighbor
            if (IDX >= i_ctl.slot) begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> rtl/positional_queue_store.sv
// Top level of the positional queue store: cell row, count and result register.
`default_nettype none

// Ordered store of up to DEPTH signed 32-bit entries, entry 0 being the head.
// Each input word carries one operation in tuser (append, remove head, insert
// at a position, delete at a position) and answers with exactly one output
// word: status in tuser, the count after the operation and the removed value
// in tdata. The whole row of cells shifts at once, so one word is taken per
// clock while the output is not stalled, and its result shows in the output
// register on the next cycle. The input stays ready while a result waits, as
// long as that result is taken in the same cycle. Failed operations leave
// the store untouched and return zero as removed value. Entries are not
// cleared at reset, but the count is; slots at or past it are never read.

module positional_queue_store
    import pqs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // value[31:0], position[36:32], zero fill
    input  wire logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [39:0] o_m_tdata,   // count[4:0], removed_value[36:5], zero fill
    output logic      [1:0]  o_m_tuser    // status[1:0]
);

    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned IW   = $clog2(DEPTH);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

    logic              w_accept;
    logic [DATA_W-1:0] w_value;
    logic [POS_W-1:0]  w_position;
    t_op               w_op;
    logic [CMPW-1:0]   w_pos_x;
    logic [CMPW-1:0]   w_cnt_x;
    logic              w_full;
    logic              w_empty;
    logic [CMPW-1:0]   w_slot;
    logic              w_ins;
    logic              w_del;
    t_status           w_status;
    t_cell_ctl         w_ctl;
    logic [DATA_W-1:0] w_entries [DEPTH];
    logic [DATA_W-1:0] w_removed;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_valid;
    t_status           r_status;
    logic [CNT_W-1:0]  r_count_out;
    logic [DATA_W-1:0] r_removed;

    assign o_s_tready = i_rst_n && (!r_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_value    = i_s_tdata[DATA_W-1:0];
    assign w_position = i_s_tdata[DATA_W+POS_W-1:DATA_W];
    assign w_op       = t_op'(i_s_tuser);

    assign w_pos_x = CMPW'(w_position);
    assign w_cnt_x = CMPW'(r_count);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_slot   = '0;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_status = ST_DONE;
        unique case (w_op)
            OP_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins  = 1'b1;
                    w_slot = w_cnt_x;
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_del = 1'b1;
                end
            end
            OP_INSERT: begin
                // range is checked before fullness
                if (w_pos_x > w_cnt_x) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins  = 1'b1;
                    w_slot = w_pos_x;
                end
            end
            OP_DELETE: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_del  = 1'b1;
                    w_slot = w_pos_x;
                end
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
    end

    assign w_ctl.ins   = w_accept && w_ins;
    assign w_ctl.del   = w_accept && w_del;
    assign w_ctl.slot  = SLOT_W'(w_slot);
    assign w_ctl.value = w_value;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;

        if (g == 0) begin : g_head
            assign w_prev = w_entries[g];
        end else begin : g_mid_prev
            assign w_prev = w_entries[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_entries[g];
        end else begin : g_mid_next
            assign w_next = w_entries[g+1];
        end

        pqs_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_entries[g])
        );
    end

    assign w_removed = w_del ? w_entries[w_slot[IW-1:0]] : '0;

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_count_out <= CNT_W'(n_count);
            r_removed   <= w_removed;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {3'd0, r_removed, r_count_out};

endmodule

`default_nettype wire

>>> rtl/pqs_checker.sv
// Port-level checker for the positional queue store, bound to the top level.
`default_nettype none

module pqs_checker
    import pqs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser
);

    // every accepted word shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted word produced no result");

    // a stalled result must hold
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result changed");

    // failed operations return zero as removed value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_DONE) |-> (o_m_tdata[36:5] == 32'd0))
        else $error("failed operation returned a removed value");

    // an empty status comes only from an empty store
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_EMPTY) |-> (o_m_tdata[4:0] == 5'd0))
        else $error("empty status with nonzero count");

    // count never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (DEPTH > 31) || (32'(o_m_tdata[4:0]) <= DEPTH))
        else $error("count beyond depth");

endmodule

bind positional_queue_store pqs_checker #(.DEPTH(DEPTH)) u_pqs_checker (.*);

`default_nettype wire

>>> bench/pqs_checker.sv
// Watches both streams of the positional queue store, predicts every result and compares.
`timescale 1ns / 1ps

module pqs_tb_checker
    import pqs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [39:0] i_s_tdata,   // value[31:0], position[36:32], zero fill
    input  wire logic [1:0]  i_s_tuser,   // operation[1:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [39:0] i_m_tdata,   // count[4:0], removed_value[36:5], zero fill
    input  wire logic [1:0]  i_m_tuser,   // status[1:0]
    output int               o_faults,
    output int               o_pending,
    output int               o_held
);

    typedef struct {
        t_status           status;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] removed;
    } t_result;

    logic [DATA_W-1:0] slots [DEPTH];
    int                held = 0;
    t_result           results_due [$];
    t_result           want;
    t_result           got;
    t_result           fresh;

    initial begin
        o_faults  = 0;
        o_pending = 0;
        o_held    = 0;
    end

    task automatic note_fault(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_faults++;
    endtask

    // apply one operation to the shadow store and return the word it answers with
    task automatic apply_op(input t_op op, input logic [DATA_W-1:0] val,
                            input logic [POS_W-1:0] pos, output t_result res);
        int p;
        int i;
        p           = int'(pos);
        res.status  = ST_DONE;
        res.removed = '0;
        case (op)
            OP_APPEND: begin
                if (held >= int'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    slots[held] = val;
                    held++;
                end
            end
            OP_POP: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.removed = slots[0];
                    for (i = 0; i < held - 1; i++) slots[i] = slots[i+1];
                    held--;
                end
            end
            OP_INSERT: begin
                // range is checked before fullness
                if (p > held) begin
                    res.status = ST_RANGE;
                end else if (held >= int'(DEPTH)) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = held; i > p; i--) slots[i] = slots[i-1];
                    slots[p] = val;
                    held++;
                end
            end
            default: begin
                if (p >= held) begin
                    res.status = ST_RANGE;
                end else begin
                    res.removed = slots[p];
                    for (i = p; i < held - 1; i++) slots[i] = slots[i+1];
                    held--;
                end
            end
        endcase
        res.count = held[CNT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            results_due.delete();
        end else begin
            // compare first so a stray word cannot match the word taken this edge
            if (i_m_tvalid && i_m_tready) begin
                got.status  = t_status'(i_m_tuser);
                got.count   = i_m_tdata[4:0];
                got.removed = i_m_tdata[36:5];
                if (results_due.size() == 0) begin
                    note_fault($sformatf("result word with nothing pending: st=%0d cnt=%0d",
                                         got.status, got.count));
                end else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status)
                        note_fault($sformatf("status got %0d want %0d",
                                             got.status, want.status));
                    if (got.count !== want.count)
                        note_fault($sformatf("count got %0d want %0d",
                                             got.count, want.count));
                    if (got.removed !== want.removed)
                        note_fault($sformatf("removed value got %h want %h",
                                             got.removed, want.removed));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_op(t_op'(i_s_tuser), i_s_tdata[31:0], i_s_tdata[36:32], fresh);
                results_due.push_back(fresh);
            end
        end
        o_pending = results_due.size();
        o_held    = held;
    end

endmodule

>>> bench/tb_positional_queue_store.sv
// Stimulus and verdict for the positional queue store.
`timescale 1ns / 1ps

module tb_positional_queue_store;
    import pqs_pkg::*;

    localparam int unsigned DEPTH = 16;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [39:0] s_tdata    = '0;
    logic [1:0]  s_tuser    = '0;
    logic        m_tready   = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    int          faults;
    int          pending;
    int          held;
    bit          idle_on    = 1'b1;
    int          stall_left = 0;

    always #5 i_clk = ~i_clk;

    positional_queue_store #(.DEPTH(DEPTH)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    pqs_tb_checker #(.DEPTH(DEPTH)) u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .o_faults   (faults),
        .o_pending  (pending),
        .o_held     (held)
    );

    // receiver: stall in bursts while idling is on
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(0, 16);
        end else begin
            m_tready = 1'b1;
        end
    end

    // present one word at a falling edge and hold it until taken
    task automatic send_word(input t_op op, input logic [31:0] v, input logic [4:0] p);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap      = $urandom_range(1, 17);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, p, v};
        s_tuser  = op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int          n;
        int          roll;
        bit          grow;
        t_op         op;
        logic [31:0] v;
        logic [4:0]  p;

        grow = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // empty store corner cases
        send_word(OP_POP,    32'h0000_0000, 5'd0);
        send_word(OP_DELETE, 32'h0000_0000, 5'd0);
        send_word(OP_INSERT, 32'h1234_5678, 5'd1);
        // extremes of value, insert at head and at tail
        send_word(OP_INSERT, 32'h8000_0000, 5'd0);
        send_word(OP_APPEND, 32'h7FFF_FFFF, 5'd31);
        send_word(OP_APPEND, 32'hFFFF_FFFF, 5'd0);
        send_word(OP_INSERT, 32'h0000_0000, 5'd3);
        send_word(OP_INSERT, 32'h5555_5555, 5'd1);
        // delete last, then at and past the count
        send_word(OP_DELETE, 32'hAAAA_AAAA, 5'd4);
        send_word(OP_DELETE, 32'h0000_0000, 5'd4);
        send_word(OP_DELETE, 32'h0000_0000, 5'd16);
        send_word(OP_POP,    32'hFFFF_FFFF, 5'd16);
        // fill up, then hit the full store
        while (held < int'(DEPTH)) send_word(OP_APPEND, $urandom, 5'($urandom_range(0, 16)));
        send_word(OP_APPEND, 32'h0BAD_0BAD, 5'd0);
        send_word(OP_INSERT, 32'h0BAD_0BAD, 5'd16);
        send_word(OP_INSERT, 32'h0BAD_0BAD, 5'd7);
        send_word(OP_DELETE, 32'h0000_0000, 5'd15);

        for (n = 0; n < 1050; n++) begin
            // swing between filling and draining so both ends get exercised
            if (n % 40 == 0) grow = ~grow;
            idle_on = (n < 900);
            roll    = $urandom_range(0, 99);
            if (roll < 8) begin
                op = t_op'($urandom_range(0, 3));
                p  = 5'($urandom_range(0, 16));
            end else if (grow) begin
                op = (roll < 50) ? OP_APPEND : OP_INSERT;
                if (roll > 90 && held < 16) p = 5'($urandom_range(held + 1, 16));
                else                        p = 5'($urandom_range(0, held));
            end else begin
                op = (roll < 50) ? OP_POP : OP_DELETE;
                if (roll > 90 || held == 0) p = 5'($urandom_range(held, 16));
                else                        p = 5'($urandom_range(0, held - 1));
            end
            case ($urandom_range(0, 9))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'hFFFF_FFFF;
                3:       v = 32'h0000_0000;
                default: v = $urandom;
            endcase
            send_word(op, v, p);
        end
        s_tvalid = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (faults == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pqs_pkg.sv
rtl/pqs_cell.sv
rtl/positional_queue_store.sv
rtl/pqs_checker.sv
bench/pqs_checker.sv
bench/tb_positional_queue_store.sv
